[rtl/assert_macros.svh]
// ---------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the stream matcher checkers.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

[rtl/mpsm_pkg.sv]
// ---------------------------------------------------------------------------
// mpsm_pkg
// Sizes, field codes and control structs of the multi-pattern stream matcher.
// ---------------------------------------------------------------------------
package mpsm_pkg;

  localparam int NUM_PATTERNS    = 8;
  localparam int MAX_PATTERN_LEN = 32;
  localparam int CAPTURE_DEPTH   = 32;

  // fixed field widths
  localparam int FUNC_W  = 2;
  localparam int BYTE_W  = 8;
  localparam int SLOT_W  = 3;
  localparam int CPOS_W  = 5;
  localparam int PLEN_W  = 6;
  localparam int KIND_W  = 2;
  localparam int COUNT_W = 5;

  // derived internal widths
  localparam int POS_W  = $clog2(MAX_PATTERN_LEN);
  localparam int LEN_W  = $clog2(MAX_PATTERN_LEN + 1);
  localparam int FILL_W = $clog2(CAPTURE_DEPTH);
  localparam int TMO_W  = 32;

  // APB
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  // input item functions
  localparam logic [FUNC_W-1:0] FUNC_BYTE = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_TICK = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CHAR = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_LEN  = 2'd3;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_BYTE     = 2'd0;
  localparam logic [KIND_W-1:0] KIND_MATCH    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_TIMEOUT  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_OVERFLOW = 2'd3;

  typedef struct packed {
    logic             capture_enable;
    logic [TMO_W-1:0] timeout_ticks;
  } mpsm_cfg_t;

  // controller -> datapath
  typedef struct packed {
    logic accept;       // input transfer this cycle
    logic eval;         // evaluate the latched stream byte
    logic dump_load;    // load next captured byte into the output register
    logic status_load;  // load the pending status into the output register
  } mpsm_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic tick_fire;  // a tick now would reach the timeout
    logic match;      // evaluated byte completes a pattern
    logic dump;       // match with captured bytes to emit
    logic overflow;   // unmatched byte hits a full capture store
    logic dump_done;  // current captured byte is the last one
    logic out_free;   // output register can take a result
  } mpsm_stat_t;

endpackage

[rtl/mpsm_in_if.sv]
// ---------------------------------------------------------------------------
// mpsm_in_if
// Input item channel: valid/ready handshake and the command fields.
// ---------------------------------------------------------------------------
interface mpsm_in_if;
  logic                         valid;
  logic                         ready;
  logic [mpsm_pkg::FUNC_W-1:0]  func;
  logic [mpsm_pkg::BYTE_W-1:0]  data_byte;
  logic [mpsm_pkg::SLOT_W-1:0]  pattern_slot;
  logic [mpsm_pkg::CPOS_W-1:0]  char_position;
  logic [mpsm_pkg::PLEN_W-1:0]  pattern_length;

  modport source (
    output valid, func, data_byte, pattern_slot, char_position, pattern_length,
    input  ready
  );
  modport sink (
    input  valid, func, data_byte, pattern_slot, char_position, pattern_length,
    output ready
  );
endinterface

[rtl/mpsm_out_if.sv]
// ---------------------------------------------------------------------------
// mpsm_out_if
// Result item channel: valid/ready handshake and the result fields.
// ---------------------------------------------------------------------------
interface mpsm_out_if;
  logic                          valid;
  logic                          ready;
  logic [mpsm_pkg::KIND_W-1:0]   kind;
  logic [mpsm_pkg::BYTE_W-1:0]   out_byte;
  logic [mpsm_pkg::SLOT_W-1:0]   match_slot;
  logic [mpsm_pkg::COUNT_W-1:0]  captured_count;
  logic                          last;

  modport source (
    output valid, kind, out_byte, match_slot, captured_count, last,
    input  ready
  );
  modport sink (
    input  valid, kind, out_byte, match_slot, captured_count, last,
    output ready
  );
endinterface

[rtl/mpsm_regs.sv]
// ---------------------------------------------------------------------------
// mpsm_regs
// APB register file: capture enable and timeout limit.
// ---------------------------------------------------------------------------
module mpsm_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [mpsm_pkg::PADDR_W-1:0]   paddr,
  input  logic [mpsm_pkg::PDATA_W-1:0]   pwdata,
  output logic [mpsm_pkg::PDATA_W-1:0]   prdata,
  output logic                           pready,
  output mpsm_pkg::mpsm_cfg_t            cfg
);

  localparam logic REG_CAPTURE_ENABLE = 1'b0;
  localparam logic REG_TIMEOUT_TICKS  = 1'b1;

  logic wr_en;
  logic reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_sel = paddr[2];   // word index, byte lanes ignored

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      case (reg_sel)
        REG_CAPTURE_ENABLE: cfg.capture_enable <= pwdata[0];
        REG_TIMEOUT_TICKS:  cfg.timeout_ticks  <= pwdata[mpsm_pkg::TMO_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_CAPTURE_ENABLE: prdata = {{(mpsm_pkg::PDATA_W-1){1'b0}}, cfg.capture_enable};
      REG_TIMEOUT_TICKS:  prdata = mpsm_pkg::PDATA_W'(cfg.timeout_ticks);
      default:            prdata = '0;
    endcase
  end

endmodule

[rtl/mpsm_ctrl.sv]
// ---------------------------------------------------------------------------
// mpsm_ctrl
// Sequencer: takes an item, evaluates stream bytes, emits result runs.
// ---------------------------------------------------------------------------
module mpsm_ctrl (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic [mpsm_pkg::FUNC_W-1:0]  func,
  output logic                         in_ready,
  input  mpsm_pkg::mpsm_stat_t         stat,
  output mpsm_pkg::mpsm_cmd_t          cmd
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_EVAL   = 4'b0010,
    ST_DUMP   = 4'b0100,
    ST_STATUS = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.accept = in_valid && in_ready;
    case (state)
      ST_IDLE: begin
        if (cmd.accept) begin
          if (func == mpsm_pkg::FUNC_BYTE) begin
            state_next = ST_EVAL;
          end else if (func == mpsm_pkg::FUNC_TICK && stat.tick_fire) begin
            state_next = ST_STATUS;
          end
        end
      end
      ST_EVAL: begin
        cmd.eval = 1'b1;
        if (stat.dump) begin
          state_next = ST_DUMP;
        end else if (stat.match || stat.overflow) begin
          state_next = ST_STATUS;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_DUMP: begin
        if (stat.out_free) begin
          cmd.dump_load = 1'b1;
          if (stat.dump_done) begin
            state_next = ST_STATUS;
          end
        end
      end
      ST_STATUS: begin
        if (stat.out_free) begin
          cmd.status_load = 1'b1;
          state_next      = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

[rtl/mpsm_datapath.sv]
// ---------------------------------------------------------------------------
// mpsm_datapath
// Pattern memories, per-slot match positions, capture store, idle timer
// and the output register.
// ---------------------------------------------------------------------------
module mpsm_datapath (
  input  logic                           clk,
  input  logic                           rst,
  input  mpsm_pkg::mpsm_cfg_t            cfg,
  input  mpsm_pkg::mpsm_cmd_t            cmd,
  output mpsm_pkg::mpsm_stat_t           stat,
  input  logic [mpsm_pkg::FUNC_W-1:0]    func,
  input  logic [mpsm_pkg::BYTE_W-1:0]    data_byte,
  input  logic [mpsm_pkg::SLOT_W-1:0]    pattern_slot,
  input  logic [mpsm_pkg::CPOS_W-1:0]    char_position,
  input  logic [mpsm_pkg::PLEN_W-1:0]    pattern_length,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [mpsm_pkg::KIND_W-1:0]    kind,
  output logic [mpsm_pkg::BYTE_W-1:0]    out_byte,
  output logic [mpsm_pkg::SLOT_W-1:0]    match_slot,
  output logic [mpsm_pkg::COUNT_W-1:0]   captured_count,
  output logic                           last
);

  localparam int NP  = mpsm_pkg::NUM_PATTERNS;
  localparam int PW  = mpsm_pkg::POS_W;
  localparam int LW  = mpsm_pkg::LEN_W;
  localparam int FW  = mpsm_pkg::FILL_W;
  localparam int BW  = mpsm_pkg::BYTE_W;
  localparam int SW  = mpsm_pkg::SLOT_W;
  localparam int TW  = mpsm_pkg::TMO_W;

  // per-slot state
  logic [LW-1:0] len [NP];
  logic [PW-1:0] pos [NP];
  logic [BW-1:0] char_q [NP];

  // evaluation
  logic [BW-1:0] data_q;
  logic [LW-1:0] new_pos [NP];
  logic [NP-1:0] active;
  logic [NP-1:0] done;
  logic          act;
  logic          match_any;
  logic [SW-1:0] first;

  // capture
  logic [BW-1:0] cap_mem [mpsm_pkg::CAPTURE_DEPTH];
  logic [FW-1:0] fill;
  logic          cap_full;
  logic [FW-1:0] idx;
  logic [FW-1:0] rd_addr;
  logic [BW-1:0] rd_q;
  logic [FW-1:0] dump_cnt;

  // timer
  logic [TW-1:0] idle;
  logic [TW-1:0] idle_inc;
  logic          tick_fire;

  // pending status
  logic [mpsm_pkg::KIND_W-1:0]  st_kind;
  logic [SW-1:0]                st_slot;
  logic [mpsm_pkg::COUNT_W-1:0] st_count;

  logic slot_ok;
  logic cpos_ok;
  logic pat_we;
  logic cap_we;
  logic [LW-1:0] len_sat;

  assign slot_ok = ({1'b0, pattern_slot} < (SW + 1)'(NP));
  assign cpos_ok = ({1'b0, char_position} < (mpsm_pkg::CPOS_W + 1)'(mpsm_pkg::MAX_PATTERN_LEN));
  assign pat_we  = cmd.accept && func == mpsm_pkg::FUNC_CHAR && slot_ok && cpos_ok;
  assign len_sat = (pattern_length > mpsm_pkg::PLEN_W'(mpsm_pkg::MAX_PATTERN_LEN)) ?
                   LW'(mpsm_pkg::MAX_PATTERN_LEN) : LW'(pattern_length);

  // one pattern memory per slot, read continuously at that slot's position
  for (genvar g = 0; g < NP; g++) begin : g_slot
    logic [BW-1:0] pat_mem [mpsm_pkg::MAX_PATTERN_LEN];

    always_ff @(posedge clk) begin
      if (pat_we && pattern_slot == SW'(g)) begin
        pat_mem[char_position[PW-1:0]] <= data_byte;
      end
      char_q[g] <= pat_mem[pos[g]];
    end
  end

  // slot compare; list ends at the first empty slot, first completion wins
  always_comb begin
    act   = 1'b1;
    first = '0;
    for (int i = 0; i < NP; i++) begin
      act        = act && (len[i] != '0);
      active[i]  = act;
      new_pos[i] = (char_q[i] == data_q) ? LW'(pos[i]) + LW'(1) : '0;
      done[i]    = act && (new_pos[i] >= len[i]);
    end
    for (int i = NP - 1; i >= 0; i--) begin
      if (done[i]) begin
        first = SW'(i);
      end
    end
  end

  assign match_any = |done;
  assign cap_full  = (fill == FW'(mpsm_pkg::CAPTURE_DEPTH - 1));
  assign cap_we    = cmd.eval && !match_any && cfg.capture_enable && !cap_full;

  assign idle_inc  = (idle == '1) ? idle : idle + TW'(1);
  assign tick_fire = (cfg.timeout_ticks != '0) && (idle_inc >= cfg.timeout_ticks);

  always_comb begin
    if (cmd.eval) begin
      rd_addr = '0;
    end else if (cmd.dump_load) begin
      rd_addr = idx + FW'(1);
    end else begin
      rd_addr = idx;
    end
  end

  assign stat.tick_fire = tick_fire;
  assign stat.match     = match_any;
  assign stat.dump      = match_any && cfg.capture_enable && (fill != '0);
  assign stat.overflow  = !match_any && cfg.capture_enable && cap_full;
  assign stat.dump_done = ((FW + 1)'(idx) + (FW + 1)'(1)) == (FW + 1)'(dump_cnt);
  assign stat.out_free  = !out_valid || out_ready;

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
      idle <= '0;
      for (int i = 0; i < NP; i++) begin
        len[i] <= '0;
        pos[i] <= '0;
      end
    end else begin
      if (cmd.accept) begin
        case (func)
          mpsm_pkg::FUNC_BYTE: idle <= '0;
          mpsm_pkg::FUNC_TICK: begin
            if (cfg.timeout_ticks != '0) begin
              idle <= tick_fire ? '0 : idle_inc;
            end
          end
          mpsm_pkg::FUNC_LEN: begin
            if (slot_ok) begin
              len[pattern_slot] <= len_sat;
              pos[pattern_slot] <= '0;
            end
          end
          default: ;
        endcase
      end
      if (cmd.eval) begin
        if (match_any) begin
          fill <= '0;
          for (int i = 0; i < NP; i++) begin
            pos[i] <= '0;
          end
        end else begin
          for (int i = 0; i < NP; i++) begin
            if (active[i]) begin
              pos[i] <= PW'(new_pos[i]);
            end
          end
          if (cfg.capture_enable) begin
            fill <= cap_full ? '0 : fill + FW'(1);
          end
        end
      end
    end
  end

  // capture store and payload
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      data_q <= data_byte;
    end
    if (cap_we) begin
      cap_mem[fill] <= data_q;
    end
    rd_q <= cap_mem[rd_addr];
    idx  <= rd_addr;
    if (cmd.accept && func == mpsm_pkg::FUNC_TICK) begin
      st_kind  <= mpsm_pkg::KIND_TIMEOUT;
      st_slot  <= '0;
      st_count <= '0;
    end else if (cmd.eval) begin
      dump_cnt <= cfg.capture_enable ? fill : '0;
      if (match_any) begin
        st_kind  <= mpsm_pkg::KIND_MATCH;
        st_slot  <= first;
        st_count <= cfg.capture_enable ? mpsm_pkg::COUNT_W'(fill) : '0;
      end else begin
        st_kind  <= mpsm_pkg::KIND_OVERFLOW;
        st_slot  <= '0;
        st_count <= '0;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.dump_load || cmd.status_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.dump_load) begin
      kind           <= mpsm_pkg::KIND_BYTE;
      out_byte       <= rd_q;
      match_slot     <= '0;
      captured_count <= '0;
      last           <= 1'b0;
    end else if (cmd.status_load) begin
      kind           <= st_kind;
      out_byte       <= '0;
      match_slot     <= st_slot;
      captured_count <= st_count;
      last           <= 1'b1;
    end
  end

endmodule

[rtl/multi_pattern_stream_matcher.sv]
// ---------------------------------------------------------------------------
// multi_pattern_stream_matcher
// Watches a byte stream for up to eight loaded strings at once. Each slot
// keeps its own match position; a byte equal to the slot's next character
// advances it, any other byte sends it back to zero without retesting that
// byte against the first character. Slots are scanned in order and the list
// stops at the first slot of length zero. On a completed pattern the block
// sends the bytes captured before it (one result transfer each, when capture
// is enabled), then a match status carrying the slot and the byte count,
// and clears every position and the capture store. An unmatched byte
// arriving at a full store (31 bytes held) gives an overflow status and
// empties the store. Ticks count idle time; reaching a nonzero limit gives a
// timeout status and restarts the count, match progress untouched. The last
// result of each item is flagged with last. Character writes, length writes
// and ticks that give no result are taken in the idle state; a stream byte
// also passes an evaluate state, as the per-slot pattern memories have a
// registered read. A status passes a status state; a match first sends its
// captured bytes one by one through the capture store's single read port.
// Results wait while ready is low. The result register lets the next item
// in while the final result of a run still waits to be taken. Pattern and
// capture stores come up undefined and need no clearing pass. Registers on
// the APB port: capture_enable at 0x0, timeout_ticks at 0x4; write only
// while the block is idle.
// ---------------------------------------------------------------------------
module multi_pattern_stream_matcher (
  input  logic                           clk,
  input  logic                           rst,
  mpsm_in_if.sink                        in_ch,
  mpsm_out_if.source                     out_ch,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [mpsm_pkg::PADDR_W-1:0]   paddr,
  input  logic [mpsm_pkg::PDATA_W-1:0]   pwdata,
  output logic [mpsm_pkg::PDATA_W-1:0]   prdata,
  output logic                           pready
);

  mpsm_pkg::mpsm_cfg_t  cfg;
  mpsm_pkg::mpsm_cmd_t  cmd;
  mpsm_pkg::mpsm_stat_t stat;

  // configuration registers
  mpsm_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // sequencer: owns the input handshake and the order of result transfers
  mpsm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .func     (in_ch.func),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // compare, capture, timer and output register
  mpsm_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .cmd            (cmd),
    .stat           (stat),
    .func           (in_ch.func),
    .data_byte      (in_ch.data_byte),
    .pattern_slot   (in_ch.pattern_slot),
    .char_position  (in_ch.char_position),
    .pattern_length (in_ch.pattern_length),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .kind           (out_ch.kind),
    .out_byte       (out_ch.out_byte),
    .match_slot     (out_ch.match_slot),
    .captured_count (out_ch.captured_count),
    .last           (out_ch.last)
  );

endmodule

[rtl/mpsm_checker.sv]
// ---------------------------------------------------------------------------
// mpsm_checker
// Port-level checks on the stream matcher, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module mpsm_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [mpsm_pkg::KIND_W-1:0]    kind,
  input logic [mpsm_pkg::BYTE_W-1:0]    out_byte,
  input logic [mpsm_pkg::SLOT_W-1:0]    match_slot,
  input logic [mpsm_pkg::COUNT_W-1:0]   captured_count,
  input logic                           last
);

  logic is_byte;
  logic is_match;

  assign is_byte  = out_valid && kind == mpsm_pkg::KIND_BYTE;
  assign is_match = out_valid && kind == mpsm_pkg::KIND_MATCH;

  // a captured byte is always followed by its match status, so no item
  // may be taken while one is on offer
  `ASSERT_IMPLY(a_dump_blocks_input, clk, rst, is_byte, !in_ready)

  // status results close a run and carry no byte
  `ASSERT_IMPLY(a_status_is_last, clk, rst, out_valid && !is_byte, last && out_byte == '0)

  // slot and count only travel on a match status
  `ASSERT_IMPLY(a_match_fields, clk, rst, out_valid && !is_match,
                match_slot == '0 && captured_count == '0)

  // stalled result holds
  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready,
               out_valid && $stable(kind) && $stable(out_byte) && $stable(last))

endmodule

bind multi_pattern_stream_matcher mpsm_checker u_mpsm_checker (
  .clk            (clk),
  .rst            (rst),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .kind           (out_ch.kind),
  .out_byte       (out_ch.out_byte),
  .match_slot     (out_ch.match_slot),
  .captured_count (out_ch.captured_count),
  .last           (out_ch.last)
);

[tb/mpsm_tb_pkg.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// mpsm_tb_pkg
// Register map of the stream matcher as the testbench sees it on APB.
// ---------------------------------------------------------------------------
package mpsm_tb_pkg;

  localparam logic [mpsm_pkg::PADDR_W-1:0] REG_CAPTURE_ENABLE = 'h0;
  localparam logic [mpsm_pkg::PADDR_W-1:0] REG_TIMEOUT_TICKS  = 'h4;

endpackage

[tb/mpsm_checker.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// mpsm_scoreboard
// Watches both channels and the APB port, keeps its own copy of the matcher
// state, predicts the results of every input transfer and compares each
// result transfer against the oldest prediction.
// ---------------------------------------------------------------------------
module mpsm_scoreboard (
  input  logic                          clk,
  input  logic                          rst,
  mpsm_in_if                            in_mon,
  mpsm_out_if                           out_mon,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic                          pready,
  input  logic [mpsm_pkg::PADDR_W-1:0]  paddr,
  input  logic [mpsm_pkg::PDATA_W-1:0]  pwdata,
  output int                            fail_count,
  output int                            results_awaited
);
  import mpsm_pkg::*;
  import mpsm_tb_pkg::*;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [BYTE_W-1:0]  out_byte;
    logic [SLOT_W-1:0]  match_slot;
    logic [COUNT_W-1:0] captured_count;
    logic               last;
  } matcher_result_t;

  logic [BYTE_W-1:0]  slot_chars [NUM_PATTERNS][MAX_PATTERN_LEN];
  logic [PLEN_W-1:0]  slot_len   [NUM_PATTERNS];
  logic [PLEN_W-1:0]  slot_pos   [NUM_PATTERNS];
  logic [BYTE_W-1:0]  held_bytes [CAPTURE_DEPTH];
  logic [COUNT_W-1:0] held_count;
  logic [TMO_W-1:0]   quiet_ticks;
  logic               cap_on;
  logic [TMO_W-1:0]   tick_limit;

  matcher_result_t awaited_results [$];

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      fail_count++;
    end
  endtask

  // Apply one input item to the shadow state and queue what it gives.
  task automatic advance_matcher(input logic [FUNC_W-1:0] func,
                                 input logic [BYTE_W-1:0] chr,
                                 input logic [SLOT_W-1:0] slot,
                                 input logic [CPOS_W-1:0] cpos,
                                 input logic [PLEN_W-1:0] plen);
    matcher_result_t    batch [$];
    matcher_result_t    r;
    logic [COUNT_W-1:0] dumped;
    bit                 done;
    done = 1'b0;
    case (func)
      FUNC_BYTE: begin
        quiet_ticks = '0;
        for (int i = 0; i < NUM_PATTERNS && !done; i++) begin
          if (slot_len[i] == 0) break;
          // a mismatch drops to zero with no second look at the first char
          if (slot_pos[i] < MAX_PATTERN_LEN &&
              chr == slot_chars[i][slot_pos[i][CPOS_W-1:0]])
            slot_pos[i] = slot_pos[i] + 1'b1;
          else
            slot_pos[i] = '0;
          if (slot_pos[i] >= slot_len[i]) begin
            dumped = cap_on ? held_count : '0;
            for (int j = 0; j < dumped; j++) begin
              r = '0;
              r.kind = KIND_BYTE;
              r.out_byte = held_bytes[j];
              batch.push_back(r);
            end
            r = '0;
            r.kind = KIND_MATCH;
            r.match_slot = SLOT_W'(i);
            r.captured_count = dumped;
            batch.push_back(r);
            foreach (slot_pos[k]) slot_pos[k] = '0;
            held_count = '0;
            done = 1'b1;
          end
        end
        if (!done && cap_on) begin
          if (held_count < CAPTURE_DEPTH - 1) begin
            held_bytes[held_count] = chr;
            held_count = held_count + 1'b1;
          end else begin
            // full store: byte dropped, store emptied, positions kept
            held_count = '0;
            r = '0;
            r.kind = KIND_OVERFLOW;
            batch.push_back(r);
          end
        end
      end
      FUNC_TICK: begin
        if (tick_limit != 0) begin
          if (quiet_ticks != '1) quiet_ticks = quiet_ticks + 1'b1;
          if (quiet_ticks >= tick_limit) begin
            quiet_ticks = '0;
            r = '0;
            r.kind = KIND_TIMEOUT;
            batch.push_back(r);
          end
        end
      end
      FUNC_CHAR: begin
        if (slot < NUM_PATTERNS && cpos < MAX_PATTERN_LEN)
          slot_chars[slot][cpos] = chr;
      end
      default: begin
        if (slot < NUM_PATTERNS) begin
          slot_len[slot] = (plen > MAX_PATTERN_LEN) ? PLEN_W'(MAX_PATTERN_LEN) : plen;
          slot_pos[slot] = '0;
        end
      end
    endcase
    if (batch.size() > 0) begin
      r = batch.pop_back();
      r.last = 1'b1;
      batch.push_back(r);
    end
    foreach (batch[k]) awaited_results.push_back(batch[k]);
  endtask

  always @(posedge clk) begin : watch
    matcher_result_t want;
    if (rst) begin
      foreach (slot_len[i]) slot_len[i] = '0;
      foreach (slot_pos[i]) slot_pos[i] = '0;
      held_count  = '0;
      quiet_ticks = '0;
      cap_on      = 1'b0;
      tick_limit  = '0;
      fail_count  = 0;
      awaited_results.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr)
          REG_CAPTURE_ENABLE: cap_on = pwdata[0];
          REG_TIMEOUT_TICKS:  tick_limit = pwdata;
          default: ;
        endcase
      end
      // results first: nothing accepted at this edge can already be out
      if (out_mon.valid && out_mon.ready) begin
        if (awaited_results.size() == 0) begin
          $error("result transfer with nothing awaited: kind %0d", out_mon.kind);
          fail_count++;
        end else begin
          want = awaited_results.pop_front();
          check_field("kind", 32'(want.kind), 32'(out_mon.kind));
          check_field("out_byte", 32'(want.out_byte), 32'(out_mon.out_byte));
          check_field("match_slot", 32'(want.match_slot), 32'(out_mon.match_slot));
          check_field("captured_count", 32'(want.captured_count),
                      32'(out_mon.captured_count));
          check_field("last", 32'(want.last), 32'(out_mon.last));
        end
      end
      if (in_mon.valid && in_mon.ready)
        advance_matcher(in_mon.func, in_mon.data_byte, in_mon.pattern_slot,
                        in_mon.char_position, in_mon.pattern_length);
    end
    results_awaited <= awaited_results.size();
  end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the multi-pattern stream matcher. A short
// directed run covers the corner cases, then six random phases with
// different capture/timeout settings load patterns and stream them with
// random gaps on both sides. A checker beside the block predicts and
// compares every result transfer.
// ---------------------------------------------------------------------------
module tb_top;
  import mpsm_pkg::*;
  import mpsm_tb_pkg::*;

  localparam int IDLE_PCT      = 34;   // chance per cycle that a side idles
  localparam int HOLD_CYCLES   = 250;  // one long receiver hold-off
  localparam int SETTLE_CYCLES = 8;    // covers items that give no result
  localparam int PHASE_ITEMS   = 32;
  localparam int NUM_PHASES    = 6;
  localparam logic [BYTE_W-1:0] ALPHA_BASE = 8'h61;  // small alphabet start

  logic                clk;
  logic                rst;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PADDR_W-1:0]  paddr;
  logic [PDATA_W-1:0]  pwdata;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  logic calm;     // no idling on either side while set
  logic hold_go;  // asks the receiver for its long hold-off

  int fail_count;
  int results_awaited;
  int items_sent;

  // what the stimulus has loaded, so it never streams into unwritten chars
  logic [BYTE_W-1:0] pat_text  [NUM_PATTERNS][MAX_PATTERN_LEN];
  bit                pat_known [NUM_PATTERNS][MAX_PATTERN_LEN];
  int                pat_len   [NUM_PATTERNS];

  mpsm_in_if  in_ch ();
  mpsm_out_if out_ch ();

  multi_pattern_stream_matcher dut (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  mpsm_scoreboard match_check (
    .clk             (clk),
    .rst             (rst),
    .in_mon          (in_ch),
    .out_mon         (out_ch),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .pready          (pready),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .fail_count      (fail_count),
    .results_awaited (results_awaited)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  // Receiver: random ready, one long hold-off on request, counted here.
  initial begin : receiver
    int hold_left;
    bit hold_taken;
    hold_left  = 0;
    hold_taken = 1'b0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else if (hold_go && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left  = HOLD_CYCLES;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  // One input transfer. valid is only lowered when a gap is taken, so a
  // back-to-back item never sees valid dropped and raised in one step.
  task automatic send_item(input logic [FUNC_W-1:0] f, input logic [BYTE_W-1:0] b,
                           input logic [SLOT_W-1:0] s, input logic [CPOS_W-1:0] c,
                           input logic [PLEN_W-1:0] l);
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.func           <= f;
    in_ch.data_byte      <= b;
    in_ch.pattern_slot   <= s;
    in_ch.char_position  <= c;
    in_ch.pattern_length <= l;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    items_sent++;
  endtask

  // Unused fields carry random noise; the block must ignore them.
  task automatic stream_byte(input logic [BYTE_W-1:0] b);
    send_item(FUNC_BYTE, b, SLOT_W'($urandom), CPOS_W'($urandom), PLEN_W'($urandom));
  endtask

  task automatic send_tick();
    send_item(FUNC_TICK, BYTE_W'($urandom), SLOT_W'($urandom), CPOS_W'($urandom),
              PLEN_W'($urandom));
  endtask

  task automatic put_char(input int s, input int p, input logic [BYTE_W-1:0] ch);
    send_item(FUNC_CHAR, ch, SLOT_W'(s), CPOS_W'(p), PLEN_W'($urandom));
    pat_text[s][p]  = ch;
    pat_known[s][p] = 1'b1;
  endtask

  task automatic set_length(input int s, input logic [PLEN_W-1:0] l);
    send_item(FUNC_LEN, BYTE_W'($urandom), SLOT_W'(s), CPOS_W'($urandom), l);
    pat_len[s] = (l > MAX_PATTERN_LEN) ? MAX_PATTERN_LEN : int'(l);
  endtask

  function automatic int known_prefix(input int s);
    int n;
    n = 0;
    while (n < MAX_PATTERN_LEN && pat_known[s][n]) n++;
    return n;
  endfunction

  // Mostly a four-letter alphabet so that partial matches are common.
  function automatic logic [BYTE_W-1:0] pick_char(input bit wide);
    if (wide) return BYTE_W'($urandom_range(0, 255));
    return ALPHA_BASE + BYTE_W'($urandom_range(0, 3));
  endfunction

  task automatic load_pattern(input int s, input int nchars, input logic [PLEN_W-1:0] l,
                              input bit wide);
    for (int p = 0; p < nchars; p++) put_char(s, p, pick_char(wide));
    set_length(s, l);
  endtask

  // Stream a loaded pattern, optionally with one byte broken.
  task automatic stream_pattern(input int s, input bit corrupt);
    int bad;
    logic [BYTE_W-1:0] b;
    bad = $urandom_range(0, pat_len[s] - 1);
    for (int p = 0; p < pat_len[s]; p++) begin
      b = pat_text[s][p];
      if (corrupt && p == bad) b = ~b;
      stream_byte(b);
    end
  endtask

  // Sender stops until every awaited result is out and the block is quiet.
  task automatic settle();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (results_awaited != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // APB write: setup, access, then an idle phase with psel low so writes never abut.
  task automatic write_reg(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(input logic cap, input logic [TMO_W-1:0] tmo);
    settle();
    write_reg(REG_CAPTURE_ENABLE, {{(PDATA_W-1){1'b0}}, cap});
    write_reg(REG_TIMEOUT_TICKS, tmo);
  endtask

  initial begin : stimulus
    logic             cap_set [NUM_PHASES];
    logic [TMO_W-1:0] tmo_set [NUM_PHASES];
    int target;
    int r;
    int s;
    int n;
    int l;

    rst                  <= 1'b1;
    psel                 <= 1'b0;
    penable              <= 1'b0;
    pwrite               <= 1'b0;
    paddr                <= '0;
    pwdata               <= '0;
    in_ch.valid          <= 1'b0;
    in_ch.func           <= FUNC_BYTE;
    in_ch.data_byte      <= '0;
    in_ch.pattern_slot   <= '0;
    in_ch.char_position  <= '0;
    in_ch.pattern_length <= '0;
    calm                 <= 1'b0;
    hold_go              <= 1'b0;
    items_sent = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // ---- directed part ----
    configure(1'b1, TMO_W'(2));
    put_char(0, 0, ALPHA_BASE);
    put_char(0, 1, ALPHA_BASE + BYTE_W'(1));
    set_length(0, PLEN_W'(2));
    put_char(1, 0, 8'hFF);
    put_char(1, 1, 8'h00);
    set_length(1, PLEN_W'(2));
    // repeated first char is not retested after a mismatch; match dumps capture
    stream_byte(8'h10);
    stream_byte(ALPHA_BASE);
    stream_byte(ALPHA_BASE);
    stream_byte(ALPHA_BASE + BYTE_W'(1));
    stream_byte(ALPHA_BASE);
    stream_byte(ALPHA_BASE + BYTE_W'(1));
    // two idle ticks reach the timeout
    send_tick();
    send_tick();
    // a tick between bytes keeps match progress
    stream_byte(8'hFF);
    send_tick();
    stream_byte(8'h00);
    // zero length on slot 0 ends the list before slot 1
    set_length(0, '0);
    stream_byte(ALPHA_BASE);
    stream_byte(ALPHA_BASE + BYTE_W'(1));
    // a length write clears that slot's progress
    set_length(0, PLEN_W'(2));
    stream_byte(ALPHA_BASE);
    set_length(0, PLEN_W'(2));
    stream_byte(ALPHA_BASE + BYTE_W'(1));

    // ---- random part ----
    // every slot live, then one full-width pattern with an oversize length
    for (s = 0; s < NUM_PATTERNS; s++) begin
      l = $urandom_range(1, 3);
      load_pattern(s, l, PLEN_W'(l), 1'b0);
    end
    s = $urandom_range(0, 3);
    load_pattern(s, MAX_PATTERN_LEN, '1, 1'b1);
    stream_pattern(s, 1'b0);

    cap_set = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0};
    tmo_set = '{0, 3, 1, 32'hFFFF_FFFF, $urandom_range(2, 6), 0};
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      configure(cap_set[ph], tmo_set[ph]);
      calm <= (ph == 2);
      if (ph == 1) hold_go <= 1'b1;
      target = items_sent + PHASE_ITEMS;
      while (items_sent < target) begin
        r = $urandom_range(0, 99);
        if (r < 15) begin
          // reload, preferring the first empty slot so the list stays long
          s = $urandom_range(0, NUM_PATTERNS - 1);
          if ($urandom_range(0, 1) == 0) begin
            for (n = NUM_PATTERNS - 1; n >= 0; n--)
              if (pat_len[n] == 0) s = n;
          end
          l = ($urandom_range(0, 9) == 0) ? $urandom_range(5, MAX_PATTERN_LEN)
                                          : $urandom_range(1, 4);
          load_pattern(s, l, PLEN_W'(l), $urandom_range(0, 3) == 0);
        end else if (r < 55) begin
          s = $urandom_range(0, NUM_PATTERNS - 1);
          if (pat_len[s] == 0) begin
            stream_byte(pick_char(1'b0));
          end else begin
            repeat ($urandom_range(0, 3)) stream_byte(pick_char(1'b0));
            stream_pattern(s, $urandom_range(0, 5) == 0);
          end
        end else if (r < 70) begin
          repeat ($urandom_range(1, 6)) stream_byte(pick_char($urandom_range(0, 2) == 0));
        end else if (r < 80) begin
          repeat ($urandom_range(1, 5)) send_tick();
        end else if (r < 85) begin
          // long unmatched run to fill the capture store past its limit
          repeat (MAX_PATTERN_LEN + 1)
            stream_byte(BYTE_W'(8'h80 | $urandom_range(0, 127)));
        end else if (r < 92) begin
          s = $urandom_range(0, NUM_PATTERNS - 1);
          n = known_prefix(s);
          l = (n == MAX_PATTERN_LEN) ? $urandom_range(0, 63) : $urandom_range(0, n);
          set_length(s, PLEN_W'(l));
        end else begin
          put_char($urandom_range(0, NUM_PATTERNS - 1), $urandom_range(0, MAX_PATTERN_LEN - 1),
                   pick_char($urandom_range(0, 1) == 0));
        end
      end
    end

    settle();
    if (fail_count == 0 && results_awaited == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule
